/* rtl/core/bvr_pkg.sv */
// Shared types and constants for the bit vector range unit.
// Used by bvr_word_alu, bvr_store_ram and bit_vector_range_ops_unit.
`default_nettype none

package bvr_pkg;

    localparam int WORD_BITS    = 32;
    localparam int BIT_SEL_W    = 5;
    localparam int ACTION_W     = 3;
    localparam int INDEX_W      = 12;
    localparam int COUNT_W      = 13;
    localparam int NUM_BITS_DEF = 4096;

    typedef enum logic [ACTION_W-1:0] {
        ACT_READ_BIT   = 3'd0,
        ACT_WRITE_BIT  = 3'd1,
        ACT_FILL_RANGE = 3'd2,
        ACT_INV_BIT    = 3'd3,
        ACT_INV_RANGE  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ALU_PASS,
        ALU_SET,
        ALU_CLEAR,
        ALU_INVERT
    } alu_op_t;

    typedef struct packed {
        alu_op_t              op;
        logic [BIT_SEL_W-1:0] lo;
        logic [BIT_SEL_W-1:0] hi;
    } word_ctl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/bvr_word_alu.sv */
// Masked word update: bit mask for [lo, hi], then sets, clears, inverts or passes.
// Depends on bvr_pkg.
`default_nettype none

module bvr_word_alu
(
    input  wire bvr_pkg::word_ctl_t                  ctl,
    input  wire logic [bvr_pkg::WORD_BITS-1:0]       word_in,
    output logic      [bvr_pkg::WORD_BITS-1:0]       word_out
);

    logic [bvr_pkg::WORD_BITS-1:0] mask_lo;
    logic [bvr_pkg::WORD_BITS-1:0] mask_hi;
    logic [bvr_pkg::WORD_BITS-1:0] mask;
    logic [bvr_pkg::BIT_SEL_W-1:0] hi_gap;

    always_comb
    begin
        hi_gap  = bvr_pkg::BIT_SEL_W'(bvr_pkg::WORD_BITS - 1) - ctl.hi;
        mask_lo = {bvr_pkg::WORD_BITS{1'b1}} << ctl.lo;
        mask_hi = {bvr_pkg::WORD_BITS{1'b1}} >> hi_gap;
        mask    = mask_lo & mask_hi;
        case (ctl.op)
            bvr_pkg::ALU_SET:    word_out = word_in | mask;
            bvr_pkg::ALU_CLEAR:  word_out = word_in & ~mask;
            bvr_pkg::ALU_INVERT: word_out = word_in ^ mask;
            default:             word_out = word_in;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/bvr_store_ram.sv */
// Word store: one write port, one read port with registered read data.
// Depends on bvr_pkg.
`default_nettype none

module bvr_store_ram
#(
    parameter int DEPTH  = bvr_pkg::NUM_BITS_DEF / bvr_pkg::WORD_BITS,
    parameter int ADDR_W = 7
)
(
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [ADDR_W-1:0]                 waddr,
    input  wire logic [bvr_pkg::WORD_BITS-1:0]     wdata,
    input  wire logic [ADDR_W-1:0]                 raddr,
    output logic      [bvr_pkg::WORD_BITS-1:0]     rdata
);

    logic [bvr_pkg::WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/bit_vector_range_ops_unit.sv */
// Bit vector with read, write, fill, invert and invert-range actions over a word store.
// Each item goes through a setup state, then a read and a write state per word touched (none
// when nothing is touched, one word for single-bit actions), then a done state.
// A new item is taken only in the idle state; the next item is taken while the result waits.
// After reset a clearing pass zeroes every word of the store; not ready meanwhile.
// Depends on bvr_pkg, bvr_store_ram and bvr_word_alu.
`default_nettype none

module bit_vector_range_ops_unit
#(
    parameter int NUM_BITS = bvr_pkg::NUM_BITS_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [bvr_pkg::ACTION_W-1:0]      action,
    input  wire logic [bvr_pkg::INDEX_W-1:0]       bit_index,
    input  wire logic [bvr_pkg::COUNT_W-1:0]       bit_count,
    input  wire logic                              bit_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   read_bit
);

    localparam int StoreWords = (NUM_BITS + bvr_pkg::WORD_BITS - 1) / bvr_pkg::WORD_BITS;
    localparam int AddrW      = (StoreWords > 1) ? $clog2(StoreWords) : 1;
    localparam int NbW        = $clog2(NUM_BITS + 1);
    localparam int EndW       = (NbW > bvr_pkg::COUNT_W + 1) ? NbW : bvr_pkg::COUNT_W + 1;
    localparam int Bs         = bvr_pkg::BIT_SEL_W;

    bvr_pkg::state_t               state_reg;
    bvr_pkg::state_t               state_next;
    logic [AddrW-1:0]              clr_addr_reg;
    logic                          out_valid_reg;
    logic                          read_bit_reg;

    logic [bvr_pkg::ACTION_W-1:0]  act_reg;
    logic [bvr_pkg::INDEX_W-1:0]   idx_reg;
    logic [bvr_pkg::COUNT_W-1:0]   cnt_reg;
    logic                          val_reg;
    logic                          res_reg;
    bvr_pkg::alu_op_t              op_reg;
    logic [AddrW-1:0]              word_reg;
    logic [AddrW-1:0]              first_word_reg;
    logic [AddrW-1:0]              last_word_reg;
    logic [Bs-1:0]                 first_lo_reg;
    logic [Bs-1:0]                 last_hi_reg;

    logic                          act_known;
    bvr_pkg::alu_op_t              op_sel;
    logic [bvr_pkg::COUNT_W-1:0]   cnt_eff;
    logic [EndW-1:0]               end_raw;
    logic [EndW-1:0]               end_clip;
    logic [EndW-1:0]               last_pos;
    logic                          range_empty;

    logic                          ram_we;
    logic [AddrW-1:0]              ram_waddr;
    logic [bvr_pkg::WORD_BITS-1:0] ram_wdata;
    logic [AddrW-1:0]              ram_raddr;
    logic [bvr_pkg::WORD_BITS-1:0] ram_rdata;
    bvr_pkg::word_ctl_t            alu_ctl;
    logic [bvr_pkg::WORD_BITS-1:0] alu_word;
    logic                          load_out;

    bvr_store_ram
    #(
        .DEPTH  (StoreWords),
        .ADDR_W (AddrW)
    )
    u_store
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bvr_word_alu u_alu
    (
        .ctl      (alu_ctl),
        .word_in  (ram_rdata),
        .word_out (alu_word)
    );

    always_comb
    begin
        act_known = 1'b1;
        op_sel    = bvr_pkg::ALU_PASS;
        case (act_reg)
            bvr_pkg::ACT_READ_BIT:   op_sel = bvr_pkg::ALU_PASS;
            bvr_pkg::ACT_WRITE_BIT,
            bvr_pkg::ACT_FILL_RANGE: op_sel = val_reg ? bvr_pkg::ALU_SET : bvr_pkg::ALU_CLEAR;
            bvr_pkg::ACT_INV_BIT,
            bvr_pkg::ACT_INV_RANGE:  op_sel = bvr_pkg::ALU_INVERT;
            default:                 act_known = 1'b0;
        endcase

        if (act_reg inside {bvr_pkg::ACT_FILL_RANGE, bvr_pkg::ACT_INV_RANGE})
        begin
            cnt_eff = cnt_reg;
        end
        else
        begin
            cnt_eff = bvr_pkg::COUNT_W'(1);
        end

        end_raw     = EndW'(idx_reg) + EndW'(cnt_eff);
        end_clip    = (end_raw > EndW'(NUM_BITS)) ? EndW'(NUM_BITS) : end_raw;
        range_empty = (EndW'(idx_reg) >= end_clip);
        last_pos    = end_clip - EndW'(1);
    end

    always_comb
    begin
        alu_ctl.op = op_reg;
        alu_ctl.lo = (word_reg == first_word_reg) ? first_lo_reg : '0;
        alu_ctl.hi = (word_reg == last_word_reg) ? last_hi_reg : '1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bvr_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == AddrW'(StoreWords - 1))
                begin
                    state_next = bvr_pkg::ST_IDLE;
                end
            end
            bvr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bvr_pkg::ST_SETUP;
                end
            end
            bvr_pkg::ST_SETUP:
            begin
                if (!act_known || range_empty)
                begin
                    state_next = bvr_pkg::ST_DONE;
                end
                else
                begin
                    state_next = bvr_pkg::ST_READ;
                end
            end
            bvr_pkg::ST_READ:
            begin
                state_next = bvr_pkg::ST_WRITE;
            end
            bvr_pkg::ST_WRITE:
            begin
                if (word_reg == last_word_reg)
                begin
                    state_next = bvr_pkg::ST_DONE;
                end
                else
                begin
                    state_next = bvr_pkg::ST_READ;
                end
            end
            bvr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = bvr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bvr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = word_reg;
        ram_wdata = alu_word;
        ram_raddr = word_reg;
        load_out  = 1'b0;
        case (state_reg)
            bvr_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            bvr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            bvr_pkg::ST_WRITE:
            begin
                ram_we = (op_reg != bvr_pkg::ALU_PASS);
            end
            bvr_pkg::ST_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bvr_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == bvr_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AddrW'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg <= action;
            idx_reg <= bit_index;
            cnt_reg <= bit_count;
            val_reg <= bit_value;
            res_reg <= 1'b0;
        end
        if (state_reg == bvr_pkg::ST_SETUP)
        begin
            op_reg         <= op_sel;
            word_reg       <= AddrW'(idx_reg[bvr_pkg::INDEX_W-1:Bs]);
            first_word_reg <= AddrW'(idx_reg[bvr_pkg::INDEX_W-1:Bs]);
            last_word_reg  <= AddrW'(last_pos[EndW-1:Bs]);
            first_lo_reg   <= idx_reg[Bs-1:0];
            last_hi_reg    <= last_pos[Bs-1:0];
        end
        if (state_reg == bvr_pkg::ST_WRITE)
        begin
            word_reg <= word_reg + AddrW'(1);
            if (act_reg == bvr_pkg::ACT_READ_BIT)
            begin
                res_reg <= ram_rdata[idx_reg[Bs-1:0]];
            end
        end
        if (load_out)
        begin
            read_bit_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_bit  = read_bit_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for bit_vector_range_ops_unit: directed and random bit and range actions
// checked against a bit-level shadow of the vector, under several sender and receiver idle mixes.
// Depends on bvr_pkg and the RTL of bit_vector_range_ops_unit.
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BITS      = bvr_pkg::NUM_BITS_DEF;
    localparam int ACT_CODE_MAX  = (1 << bvr_pkg::ACTION_W) - 1;
    localparam int COUNT_MAX     = (1 << bvr_pkg::COUNT_W) - 1;
    localparam int INDEX_MAX     = (1 << bvr_pkg::INDEX_W) - 1;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int PHASE_ITEMS   = 450;
    localparam int NUM_PHASES    = 4;

    typedef struct {
        logic [bvr_pkg::ACTION_W-1:0] act;
        logic [bvr_pkg::INDEX_W-1:0]  idx;
        logic [bvr_pkg::COUNT_W-1:0]  cnt;
        logic                         val;
    } bit_op_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [bvr_pkg::ACTION_W-1:0] action;
    logic [bvr_pkg::INDEX_W-1:0]  bit_index;
    logic [bvr_pkg::COUNT_W-1:0]  bit_count;
    logic                         bit_value;
    logic                         out_valid;
    logic                         out_ready;
    logic                         read_bit;

    logic [NUM_BITS-1:0] shadow_bits;
    bit_op_t             op_queue[$];
    logic                expected_bits[$];
    bit_op_t             next_op;
    bit_op_t             fire_op;
    logic                in_taken;
    logic                exp_bit;
    int                  idle_pct;
    int                  stall_pct;
    int                  n_queued;
    int                  n_accepted;
    int                  n_errors;
    int                  quiet_cycles;
    int                  hot_base;

    bit_vector_range_ops_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .bit_index (bit_index),
        .bit_count (bit_count),
        .bit_value (bit_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_bit  (read_bit)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void update_bits(input int first, input int count,
                                        input bit invert, input logic fill);
        int stop;
        stop = first + count;
        if (stop > NUM_BITS)
            stop = NUM_BITS;
        for (int i = first; i < stop; i++)
        begin
            if (invert)
                shadow_bits[i] = ~shadow_bits[i];
            else
                shadow_bits[i] = fill;
        end
    endfunction

    function automatic logic predict_read_bit(input bit_op_t op);
        logic rd;
        rd = 1'b0;
        case (op.act)
            bvr_pkg::ACT_READ_BIT:
                if (int'(op.idx) < NUM_BITS)
                    rd = shadow_bits[op.idx];
            bvr_pkg::ACT_WRITE_BIT:  update_bits(int'(op.idx), 1, 1'b0, op.val);
            bvr_pkg::ACT_FILL_RANGE: update_bits(int'(op.idx), int'(op.cnt), 1'b0, op.val);
            bvr_pkg::ACT_INV_BIT:    update_bits(int'(op.idx), 1, 1'b1, 1'b0);
            bvr_pkg::ACT_INV_RANGE:  update_bits(int'(op.idx), int'(op.cnt), 1'b1, 1'b0);
            default:                 rd = 1'b0;
        endcase
        return rd;
    endfunction

    task automatic queue_op(input logic [bvr_pkg::ACTION_W-1:0] act, input int idx,
                            input int cnt, input logic val);
        bit_op_t op;
        op.act = act;
        op.idx = bvr_pkg::INDEX_W'(idx);
        op.cnt = bvr_pkg::COUNT_W'(cnt);
        op.val = val;
        op_queue.push_back(op);
        n_queued++;
    endtask

    task automatic queue_random_op();
        int pick;
        int idx;
        int cnt;
        logic [bvr_pkg::ACTION_W-1:0] act;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            act = bvr_pkg::ACT_READ_BIT;
        else if (pick < 50)
            act = bvr_pkg::ACT_WRITE_BIT;
        else if (pick < 65)
            act = bvr_pkg::ACT_FILL_RANGE;
        else if (pick < 80)
            act = bvr_pkg::ACT_INV_BIT;
        else if (pick < 95)
            act = bvr_pkg::ACT_INV_RANGE;
        else
            act = bvr_pkg::ACTION_W'($urandom_range(bvr_pkg::ACT_INV_RANGE + 1, ACT_CODE_MAX));
        if ($urandom_range(0, 99) < 60)
            idx = (hot_base + $urandom_range(0, 255)) & INDEX_MAX;
        else
            idx = $urandom_range(0, INDEX_MAX);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            cnt = $urandom_range(0, 70);
        else if (pick < 90)
            cnt = $urandom_range(0, 600);
        else if (pick < 97)
            cnt = $urandom_range(0, NUM_BITS);
        else
            cnt = $urandom_range(NUM_BITS + 1, COUNT_MAX);
        queue_op(act, idx, cnt, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_all_accepted();
        while (n_accepted != n_queued)
            @(posedge clk);
    endtask

    // drive inputs on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (op_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                next_op = op_queue.pop_front();
                in_valid  <= 1'b1;
                action    <= next_op.act;
                bit_index <= next_op.idx;
                bit_count <= next_op.cnt;
                bit_value <= next_op.val;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // sample transfers on the rising edge
    always @(posedge clk)
    begin
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                in_taken = 1'b1;
                fire_op.act = action;
                fire_op.idx = bit_index;
                fire_op.cnt = bit_count;
                fire_op.val = bit_value;
                expected_bits.push_back(predict_read_bit(fire_op));
                n_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_bits.size() == 0)
                begin
                    $error("read_bit: result transfer with no expected result, actual %0b",
                           read_bit);
                    n_errors++;
                end
                else
                begin
                    exp_bit = expected_bits.pop_front();
                    if (read_bit !== exp_bit)
                    begin
                        $error("read_bit mismatch: expected %0b, actual %0b", exp_bit, read_bit);
                        n_errors++;
                    end
                end
            end
            if (in_taken || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        int idle_mix[NUM_PHASES];
        int stall_mix[NUM_PHASES];
        idle_mix  = '{0, 46, 0, 33};
        stall_mix = '{0, 0, 46, 33};
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = '0;
        bit_index    = '0;
        bit_count    = '0;
        bit_value    = 1'b0;
        out_ready    = 1'b0;
        in_taken     = 1'b0;
        shadow_bits  = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        n_queued     = 0;
        n_accepted   = 0;
        n_errors     = 0;
        quiet_cycles = 0;
        hot_base     = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_op(bvr_pkg::ACT_READ_BIT,   0,         0,         1'b0);
        queue_op(bvr_pkg::ACT_WRITE_BIT,  0,         0,         1'b1);
        queue_op(bvr_pkg::ACT_READ_BIT,   0,         0,         1'b0);
        queue_op(bvr_pkg::ACT_WRITE_BIT,  INDEX_MAX, COUNT_MAX, 1'b1);
        queue_op(bvr_pkg::ACT_READ_BIT,   INDEX_MAX, 0,         1'b0);
        queue_op(bvr_pkg::ACT_FILL_RANGE, 100,       0,         1'b1);
        queue_op(bvr_pkg::ACT_READ_BIT,   100,       0,         1'b0);
        queue_op(bvr_pkg::ACT_FILL_RANGE, 30,        5,         1'b1);
        queue_op(bvr_pkg::ACT_READ_BIT,   34,        0,         1'b0);
        queue_op(bvr_pkg::ACT_INV_BIT,    31,        0,         1'b0);
        queue_op(bvr_pkg::ACT_READ_BIT,   31,        0,         1'b0);
        queue_op(bvr_pkg::ACT_INV_RANGE,  4000,      COUNT_MAX, 1'b0);
        queue_op(bvr_pkg::ACT_READ_BIT,   INDEX_MAX, 0,         1'b0);
        queue_op(bvr_pkg::ACT_FILL_RANGE, 0,         NUM_BITS,  1'b1);
        queue_op(bvr_pkg::ACT_READ_BIT,   2047,      0,         1'b0);
        queue_op(bvr_pkg::ACT_INV_RANGE,  1,         NUM_BITS - 2, 1'b0);
        queue_op(bvr_pkg::ACT_READ_BIT,   0,         0,         1'b0);
        queue_op(bvr_pkg::ACT_READ_BIT,   1,         0,         1'b0);
        queue_op(bvr_pkg::ACT_WRITE_BIT,  2048,      COUNT_MAX, 1'b0);
        queue_op(bvr_pkg::ACT_FILL_RANGE, 64,        32,        1'b0);
        queue_op(bvr_pkg::ACT_READ_BIT,   64,        0,         1'b0);
        for (int code = bvr_pkg::ACT_INV_RANGE + 1; code <= ACT_CODE_MAX; code++)
            queue_op(bvr_pkg::ACTION_W'(code), INDEX_MAX, COUNT_MAX, 1'b1);
        queue_op(bvr_pkg::ACT_READ_BIT,   INDEX_MAX, 0,         1'b0);
        queue_op(bvr_pkg::ACT_FILL_RANGE, 0,         NUM_BITS,  1'b0);
        wait_all_accepted();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idle_pct  = idle_mix[p];
            stall_pct = stall_mix[p];
            hot_base  = $urandom_range(0, INDEX_MAX);
            for (int k = 0; k < PHASE_ITEMS; k++)
                queue_random_op();
            wait_all_accepted();
        end

        while (expected_bits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
